// ===== hw/rtl/m61_pkg.sv =====
// Shared constants, operation codes and beat types for the mod 2^61-1 arithmetic unit.
package m61_pkg;

    localparam int unsigned MOD_W  = 61;
    localparam int unsigned EXP_W  = 63;
    localparam int unsigned KIND_W = 3;

    // Default multiplier digit width (bits of the multiplier consumed per cycle).
    localparam int unsigned DIGIT_W_DEF = 8;

    localparam logic [MOD_W-1:0] MODULUS = {MOD_W{1'b1}};
    // Exponent for inversion by Fermat: modulus minus two.
    localparam logic [EXP_W-1:0] INV_EXP = EXP_W'(MODULUS) - EXP_W'(2);

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEG = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POW = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INV = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MOD_W-1:0]  operand_a;
        logic [MOD_W-1:0]  operand_b;
        logic [EXP_W-1:0]  exponent;
    } t_in_item;

    typedef struct packed {
        logic [MOD_W-1:0] result;
        logic             is_equal;
        logic             is_less;
    } t_out_item;

endpackage

// ===== hw/rtl/m61_mul.sv =====
// Digit-serial modular multiplier mod 2^61-1, multiplier digits taken MSB first.
module m61_mul #(
    parameter int unsigned DIGIT_W = m61_pkg::DIGIT_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [m61_pkg::MOD_W-1:0]  i_a,
    input  logic [m61_pkg::MOD_W-1:0]  i_b,
    output logic                       o_done,
    output logic [m61_pkg::MOD_W-1:0]  o_p
);

    localparam int unsigned MW_ = m61_pkg::MOD_W;
    localparam int unsigned DIGITS = (MW_ + DIGIT_W - 1) / DIGIT_W;
    localparam int unsigned SH_W = DIGITS * DIGIT_W;
    localparam int unsigned CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int unsigned S_W = MW_ + 1 + DIGIT_W;

    logic [MW_-1:0]     r_acc,   n_acc;
    logic [MW_-1:0]     r_mcand, n_mcand;
    logic [SH_W-1:0]    r_mplier, n_mplier;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               r_busy,  n_busy;
    logic               r_done,  n_done;

    logic [DIGIT_W-1:0] w_digit;
    logic [MW_-1:0]     w_rot;
    logic [S_W-1:0]     w_prod;
    logic [S_W-1:0]     w_sum;
    logic [MW_:0]       w_f1;
    logic [MW_-1:0]     w_f2;

    // acc * 2^D mod M is a rotation; the sum is folded twice back to 61 bits.
    // Values stay lazy: the all-ones word stands for zero.
    assign w_digit = r_mplier[SH_W-1 -: DIGIT_W];
    assign w_rot   = {r_acc[MW_-DIGIT_W-1:0], r_acc[MW_-1 -: DIGIT_W]};
    assign w_prod  = S_W'(r_mcand) * S_W'(w_digit);
    assign w_sum   = S_W'(w_rot) + w_prod;
    assign w_f1    = (MW_+1)'(w_sum[MW_-1:0]) + (MW_+1)'(w_sum[S_W-1:MW_]);
    assign w_f2    = w_f1[MW_-1:0] + MW_'(w_f1[MW_]);

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (r_busy) begin
            n_acc    = w_f2;
            n_mplier = {r_mplier[SH_W-DIGIT_W-1:0], DIGIT_W'(0)};
            n_cnt    = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIGITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_acc    = '0;
            n_mcand  = i_a;
            n_mplier = SH_W'(i_b);
            n_cnt    = '0;
            n_busy   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// ===== hw/rtl/mersenne61_modular_alu.sv =====
// Top level: arithmetic unit over integers mod 2^61-1 (add, sub, mul, neg, pow, inv, div).
//
// One command beat is taken when i_start is high and o_busy is low; exactly one
// result beat follows, shown for a single cycle with o_strobe high, and the
// receiver must take it then (there is no backpressure). o_busy is low again in
// the strobe cycle, so the next command may start there. Operands equal to the
// modulus are read as zero; is_equal/is_less compare the reduced operands.
// add, sub and neg are computed in the dispatch state, and the unused code gives 0;
// mul runs D = ceil(61/DIGIT_W) digit steps of the shared digit-serial multiplier
// (8 with the default 8-bit digit).
// pow runs square-and-multiply over the exponent: each exponent bit costs one
// squaring, plus, when the bit is set, a multiply that chains straight into the
// squaring; it stops once the remaining exponent is zero. inv is pow by M-2
// (61 squarings and 60 multiplies); div is inv of operand_b followed by one
// multiply.
// The inverse of zero, and division by zero, give 0. pow with exponent 0 gives 1.
module mersenne61_modular_alu #(
    parameter int unsigned DIGIT_W = m61_pkg::DIGIT_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  m61_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_strobe,
    output m61_pkg::t_out_item o_result
);

    localparam int unsigned MW_ = m61_pkg::MOD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;   // operands registered, dispatch
    localparam logic [2:0] S_STEP = 3'd2;   // next exponent bit
    localparam logic [2:0] S_WAIT = 3'd3;   // multiplier running
    localparam logic [2:0] S_FIN  = 3'd4;   // canonicalize and strobe

    localparam logic [1:0] PH_ACC = 2'd0;   // acc = acc * sq
    localparam logic [1:0] PH_SQ  = 2'd1;   // sq = sq * sq
    localparam logic [1:0] PH_END = 2'd2;   // product is the result

    logic [2:0]                    r_state, n_state;
    logic [1:0]                    r_phase, n_phase;
    logic [m61_pkg::KIND_W-1:0]    r_kind,  n_kind;
    logic [MW_-1:0]                r_a,     n_a;
    logic [MW_-1:0]                r_b,     n_b;
    logic [m61_pkg::EXP_W-1:0]     r_exp,   n_exp;
    logic [MW_-1:0]                r_acc,   n_acc;
    logic [MW_-1:0]                r_sq,    n_sq;
    logic [MW_-1:0]                r_res,   n_res;
    logic                          r_eq,    n_eq;
    logic                          r_lt,    n_lt;
    logic                          r_strobe, n_strobe;
    m61_pkg::t_out_item            r_out,   n_out;

    logic           w_mul_start;
    logic [MW_-1:0] w_mul_a;
    logic [MW_-1:0] w_mul_b;
    logic           w_mul_done;
    logic [MW_-1:0] w_mul_p;

    logic [MW_:0]   w_sum;
    logic [MW_:0]   w_dif;

    // One conditional subtraction of M on a value below 2M.
    function automatic logic [MW_-1:0] fold_once(input logic [MW_:0] x);
        logic [MW_:0] m;
        m = {1'b0, m61_pkg::MODULUS};
        if (x >= m) begin
            return MW_'(x - m);
        end
        return x[MW_-1:0];
    endfunction

    assign w_sum = {1'b0, r_a} + {1'b0, r_b};
    assign w_dif = {1'b0, r_a} + {1'b0, m61_pkg::MODULUS} - {1'b0, r_b};

    m61_mul #(
        .DIGIT_W (DIGIT_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_a      = r_a;
        n_b      = r_b;
        n_exp    = r_exp;
        n_acc    = r_acc;
        n_sq     = r_sq;
        n_res    = r_res;
        n_eq     = r_eq;
        n_lt     = r_lt;
        n_strobe = 1'b0;
        n_out    = r_out;
        w_mul_start = 1'b0;
        w_mul_a     = r_sq;
        w_mul_b     = r_sq;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind  = i_item.kind;
                    n_a     = (i_item.operand_a == m61_pkg::MODULUS) ? '0 : i_item.operand_a;
                    n_b     = (i_item.operand_b == m61_pkg::MODULUS) ? '0 : i_item.operand_b;
                    n_exp   = i_item.exponent;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_eq  = (r_a == r_b);
                n_lt  = (r_a < r_b);
                n_acc = MW_'(1);
                n_state = S_FIN;
                case (r_kind)
                    m61_pkg::KIND_ADD: n_res = fold_once(w_sum);
                    m61_pkg::KIND_SUB: n_res = fold_once(w_dif);
                    m61_pkg::KIND_NEG: n_res = m61_pkg::MODULUS - r_a;  // zero lands on M
                    m61_pkg::KIND_MUL: begin
                        w_mul_start = 1'b1;
                        w_mul_a     = r_a;
                        w_mul_b     = r_b;
                        n_phase     = PH_END;
                        n_state     = S_WAIT;
                    end
                    m61_pkg::KIND_POW: begin
                        n_sq    = r_a;
                        n_state = S_STEP;
                    end
                    m61_pkg::KIND_INV: begin
                        n_sq    = r_a;
                        n_exp   = m61_pkg::INV_EXP;
                        n_state = S_STEP;
                    end
                    m61_pkg::KIND_DIV: begin
                        n_sq    = r_b;
                        n_exp   = m61_pkg::INV_EXP;
                        n_state = S_STEP;
                    end
                    default: n_res = '0;
                endcase
            end
            S_STEP: begin
                if (r_exp == '0) begin
                    if (r_kind == m61_pkg::KIND_DIV) begin
                        w_mul_start = 1'b1;
                        w_mul_a     = r_a;
                        w_mul_b     = r_acc;
                        n_phase     = PH_END;
                        n_state     = S_WAIT;
                    end else begin
                        n_res   = r_acc;
                        n_state = S_FIN;
                    end
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = S_WAIT;
                    if (r_exp[0]) begin
                        w_mul_a = r_acc;
                        n_phase = PH_ACC;
                    end else begin
                        n_phase = PH_SQ;
                    end
                end
            end
            S_WAIT: begin
                if (w_mul_done) begin
                    case (r_phase)
                        PH_ACC: begin
                            // chain straight into the squaring
                            n_acc       = w_mul_p;
                            w_mul_start = 1'b1;
                            n_phase     = PH_SQ;
                        end
                        PH_SQ: begin
                            n_sq    = w_mul_p;
                            n_exp   = r_exp >> 1;
                            n_state = S_STEP;
                        end
                        default: begin
                            n_res   = w_mul_p;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_FIN: begin
                n_out.result   = (r_res == m61_pkg::MODULUS) ? '0 : r_res;
                n_out.is_equal = r_eq;
                n_out.is_less  = r_lt;
                n_strobe       = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_END;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_a    <= n_a;
        r_b    <= n_b;
        r_exp  <= n_exp;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_res  <= n_res;
        r_eq   <= n_eq;
        r_lt   <= n_lt;
        r_out  <= n_out;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/m61_chk.sv =====
// Port-level checker for the mod 2^61-1 arithmetic unit, bound to the top level.
module m61_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input m61_pkg::t_in_item  i_item,
    input logic               o_busy,
    input logic               o_strobe,
    input m61_pkg::t_out_item o_result
);

    // An accepted command keeps the unit busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after accepted command");

    // Result beat shows up with the unit already free.
    a_idle_on_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy)
        else $error("strobe while busy");

    // One result per command: strobes never come back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("repeated result strobe");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.result != m61_pkg::MODULUS))
        else $error("result not reduced");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.is_equal && o_result.is_less))
        else $error("equal and less flags both set");

endmodule

bind mersenne61_modular_alu m61_chk u_chk (.*);
